FILE: rtl/tkcf_pkg.sv
// Shared types and constants for the touch key consensus filter.
`default_nettype none
package tkcf_pkg;

  localparam int PIN_W   = 4;
  localparam int COUNT_W = 12;

  // Reset value of the highest scanned pin register.
  localparam logic [PIN_W-1:0] HIGHEST_PIN_RST = 4'd8;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified sensor event.
  typedef struct packed {
    logic               store_en;  // pin lies inside the count slots
    logic [PIN_W-1:0]   pin;
    logic [COUNT_W-1:0] count;
    logic               seen;
    logic               done;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/touch_key_consensus_filter_unit.sv
// Top level of the touch key consensus filter.
//
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_stall_o    pin_index_i, touch_count_i, touch_seen_i, poll_done_i
// out      out  out_valid_o / out_stall_i  touch_active_o, winning_pin_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_highest_pin_i
//
// An event without an armed poll done goes from idle straight to the emit state; an armed poll done
// also runs the winner scan up to min(highest_pin, PIN_SLOTS-1), the history push and the history
// compare, with the single count comparator scanning one pin a cycle and the compare walking one entry a cycle.
// Reset clears counts, history and control at once; no clearing pass.
// The input register and a two-entry queue take events while a result waits on out_stall_i.
`default_nettype none
module touch_key_consensus_filter_unit #(
  parameter int HISTORY_DEPTH = 10,
  parameter int PIN_SLOTS     = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [tkcf_pkg::PIN_W-1:0]    pin_index_i,
  input  wire  [tkcf_pkg::COUNT_W-1:0]  touch_count_i,
  input  wire                           touch_seen_i,
  input  wire                           poll_done_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic                          touch_active_o,
  output logic [tkcf_pkg::PIN_W-1:0]    winning_pin_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [tkcf_pkg::PIN_W-1:0]    cfg_highest_pin_i
);
  import tkcf_pkg::*;

  logic             highest_pin_q;
  logic [PIN_W-1:0] highest_pin_r_q;
  logic             push;
  cmd_t             push_cmd;
  logic             q_ready;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  // highest_pin_q marks the register as written at least once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_pin_q   <= 1'b0;
      highest_pin_r_q <= HIGHEST_PIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      highest_pin_q   <= 1'b1;
      highest_pin_r_q <= cfg_highest_pin_i;
    end
  end

  tkcf_front #(
    .PIN_SLOTS (PIN_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pin_index_i   (pin_index_i),
    .touch_count_i (touch_count_i),
    .touch_seen_i  (touch_seen_i),
    .poll_done_i   (poll_done_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .q_ready_i     (q_ready)
  );

  tkcf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd),
    .pop_i      (pop)
  );

  tkcf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .PIN_SLOTS     (PIN_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .highest_pin_i  (highest_pin_r_q),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .touch_active_o (touch_active_o),
    .winning_pin_o  (winning_pin_o)
  );

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !highest_pin_q |-> (highest_pin_r_q == HIGHEST_PIN_RST))
    else $error("highest pin changed without a transfer");

endmodule
`default_nettype wire

FILE: rtl/tkcf_front.sv
// Front part: input register and event classification.
`default_nettype none
module tkcf_front #(
  parameter int PIN_SLOTS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [tkcf_pkg::PIN_W-1:0]     pin_index_i,
  input  wire  [tkcf_pkg::COUNT_W-1:0]   touch_count_i,
  input  wire                            touch_seen_i,
  input  wire                            poll_done_i,
  output logic                           push_o,
  output tkcf_pkg::cmd_t                 cmd_o,
  input  wire                            q_ready_i
);
  import tkcf_pkg::*;

  logic fv_q;
  cmd_t cmd_q;
  logic accept;

  assign push_o     = fv_q && q_ready_i;
  assign in_stall_o = fv_q && !q_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (push_o) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.store_en <= (32'(pin_index_i) < PIN_SLOTS);
      cmd_q.pin      <= pin_index_i;
      cmd_q.count    <= touch_count_i;
      cmd_q.seen     <= touch_seen_i;
      cmd_q.done     <= poll_done_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tkcf_queue.sv
// Short command queue between front and back parts.
`default_nettype none
module tkcf_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  tkcf_pkg::cmd_t push_cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output tkcf_pkg::cmd_t pop_cmd_o,
  input  wire            pop_i
);
  import tkcf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                do_push;
  logic                do_pop;

  assign ready_o   = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && ready_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= QUEUE_DEPTH)
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("transfer into full queue");

endmodule
`default_nettype wire

FILE: rtl/tkcf_back.sv
// Back part: count store, winner scan, history ring and result register.
`default_nettype none
module tkcf_back #(
  parameter int HISTORY_DEPTH = 10,
  parameter int PIN_SLOTS     = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [tkcf_pkg::PIN_W-1:0]   highest_pin_i,
  input  wire                          q_valid_i,
  input  tkcf_pkg::cmd_t               q_cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         touch_active_o,
  output logic [tkcf_pkg::PIN_W-1:0]   winning_pin_o
);
  import tkcf_pkg::*;

  localparam int SW   = $clog2(PIN_SLOTS);
  localparam int PTRW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] counts_q [PIN_SLOTS];
  logic [PIN_W-1:0]   hist_q [HISTORY_DEPTH];
  logic [PTRW-1:0]    ptr_q;
  logic               pending_q;
  logic               active_q;
  logic [PIN_W-1:0]   last_winner_q;
  logic [SW-1:0]      scan_idx_q;
  logic [SW-1:0]      best_q;
  logic [COUNT_W-1:0] best_cnt_q;
  logic [PTRW-1:0]    chk_idx_q;
  logic               agree_q;
  logic               out_valid_q;
  logic               out_active_q;
  logic [PIN_W-1:0]   out_pin_q;
  logic [SW-1:0]      top;
  logic               out_free;
  logic               armed;

  assign top = (32'(highest_pin_i) > PIN_SLOTS - 1) ? SW'(PIN_SLOTS - 1)
                                                    : highest_pin_i[SW-1:0];
  assign pop_o          = (state_q == S_IDLE) && q_valid_i;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign armed          = pending_q || q_cmd_i.seen;
  assign out_valid_o    = out_valid_q;
  assign touch_active_o = out_active_q;
  assign winning_pin_o  = out_pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      for (int i = 0; i < PIN_SLOTS; i++) begin
        counts_q[i] <= '0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      ptr_q         <= '0;
      pending_q     <= 1'b0;
      active_q      <= 1'b0;
      last_winner_q <= '0;
      scan_idx_q    <= '0;
      best_q        <= '0;
      best_cnt_q    <= '0;
      chk_idx_q     <= '0;
      agree_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      out_active_q  <= 1'b0;
      out_pin_q     <= '0;
    end else begin
      // in S_EMIT the load below decides the output valid on its own
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_cmd_i.store_en) begin
              counts_q[q_cmd_i.pin[SW-1:0]] <= q_cmd_i.count;
            end
            if (q_cmd_i.seen) begin
              pending_q <= 1'b1;
            end
            if (q_cmd_i.done && armed) begin
              scan_idx_q <= '0;
              best_q     <= '0;
              state_q    <= S_SCAN;
            end else begin
              if (q_cmd_i.done) begin
                // no touch this round: refill the leading ring entries
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                  if (32'(highest_pin_i) > k) begin
                    hist_q[k] <= PIN_W'(k);
                  end
                end
                active_q <= 1'b0;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          // strict compare keeps the lower pin on equal counts
          if (scan_idx_q == '0 || counts_q[scan_idx_q] > best_cnt_q) begin
            best_q     <= scan_idx_q;
            best_cnt_q <= counts_q[scan_idx_q];
          end
          if (scan_idx_q == top) begin
            state_q <= S_PUSH;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        S_PUSH: begin
          hist_q[ptr_q] <= PIN_W'(best_q);
          last_winner_q <= PIN_W'(best_q);
          ptr_q         <= (ptr_q == PTRW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          pending_q     <= 1'b0;
          chk_idx_q     <= PTRW'(1);
          agree_q       <= 1'b1;
          state_q       <= S_CHECK;
        end
        S_CHECK: begin
          // all entries equal iff each matches entry zero
          if (chk_idx_q == PTRW'(HISTORY_DEPTH - 1)) begin
            active_q <= agree_q && (hist_q[chk_idx_q] == hist_q[0]);
            state_q  <= S_EMIT;
          end else begin
            if (hist_q[chk_idx_q] != hist_q[0]) begin
              agree_q <= 1'b0;
            end
            chk_idx_q <= chk_idx_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_active_q <= active_q;
            out_pin_q    <= last_winner_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_idx_q <= top))
    else $error("winner scan past highest pin");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < HISTORY_DEPTH)
    else $error("history pointer out of range");

  a_pending_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |=> !pending_q)
    else $error("touch mark not cleared after push");

  a_emit_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded on free output");

endmodule
`default_nettype wire

FILE: tb/tkcf_checker.sv
// Transfer monitor, key state predictor and result comparison for the touch key filter.
`timescale 1ns / 1ps
module tkcf_checker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_stall_i,
  input  wire  [tkcf_pkg::PIN_W-1:0]    pin_index_i,
  input  wire  [tkcf_pkg::COUNT_W-1:0]  touch_count_i,
  input  wire                           touch_seen_i,
  input  wire                           poll_done_i,
  input  wire                           out_valid_i,
  input  wire                           out_stall_i,
  input  wire                           touch_active_i,
  input  wire  [tkcf_pkg::PIN_W-1:0]    winning_pin_i,
  input  wire                           cfg_valid_i,
  input  wire                           cfg_ready_i,
  input  wire  [tkcf_pkg::PIN_W-1:0]    cfg_highest_pin_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tkcf_pkg::*;

  localparam int HISTORY = 10;
  localparam int SLOTS   = 16;

  typedef struct packed {
    logic             active;
    logic [PIN_W-1:0] pin;
  } key_state_t;

  logic [COUNT_W-1:0] count_mem   [SLOTS];
  logic [PIN_W-1:0]   winner_ring [HISTORY];
  int unsigned        ring_ptr;
  logic               armed;
  logic               active_q;
  logic [PIN_W-1:0]   winner_q;
  logic [PIN_W-1:0]   highest_pin_q;
  key_state_t         key_state_q [$];
  int                 fails;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Update the key state with one event and queue the state it leads to.
  task automatic predict_event(input logic [PIN_W-1:0] pin, input logic [COUNT_W-1:0] cnt,
                               input logic seen, input logic done);
    logic [PIN_W-1:0] best;
    logic             agree;
    int               p;
    int               k;
    if (int'(pin) < SLOTS) count_mem[pin] = cnt;
    if (seen) armed = 1'b1;
    if (done) begin
      if (armed) begin
        best = '0;
        for (p = 1; p <= int'(highest_pin_q) && p < SLOTS; p++) begin
          // strict compare: ties keep the lower pin
          if (count_mem[p] > count_mem[best]) best = PIN_W'(p);
        end
        winner_q = best;
        if (ring_ptr >= HISTORY) ring_ptr = 0;
        winner_ring[ring_ptr] = best;
        ring_ptr++;
        if (ring_ptr >= HISTORY) ring_ptr = 0;
        agree = 1'b1;
        for (k = 0; k + 1 < HISTORY; k++) begin
          if (winner_ring[k] != winner_ring[k+1]) agree = 1'b0;
        end
        active_q = agree;
        armed    = 1'b0;
      end else begin
        // unarmed poll: refill leading entries with their index, ring pointer untouched
        for (k = 0; k < int'(highest_pin_q) && k < HISTORY; k++) begin
          winner_ring[k] = PIN_W'(k);
        end
        active_q = 1'b0;
      end
    end
    key_state_q.push_back('{active: active_q, pin: winner_q});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_state_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) count_mem[i] = '0;
      for (int i = 0; i < HISTORY; i++) winner_ring[i] = '0;
      ring_ptr      = 0;
      armed         = 1'b0;
      active_q      = 1'b0;
      winner_q      = '0;
      highest_pin_q = HIGHEST_PIN_RST;
      key_state_q.delete();
      fails         = 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (key_state_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected, winning_pin",
                          int'(winning_pin_i), 0);
        end else begin
          want = key_state_q.pop_front();
          if (touch_active_i !== want.active)
            report_mismatch("touch_active", int'(touch_active_i), int'(want.active));
          if (winning_pin_i !== want.pin)
            report_mismatch("winning_pin", int'(winning_pin_i), int'(want.pin));
        end
      end
      if (cfg_valid_i && cfg_ready_i) highest_pin_q = cfg_highest_pin_i;
      if (in_valid_i && !in_stall_i)
        predict_event(pin_index_i, touch_count_i, touch_seen_i, poll_done_i);
      pending_o <= key_state_q.size();
    end
  end

endmodule

FILE: tb/tb_touch_key_consensus_filter_unit.sv
// Stimulus and verdict for the touch key consensus filter unit.
`timescale 1ns / 1ps
module tb_touch_key_consensus_filter_unit;
  import tkcf_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 138;
  localparam int DRAIN_WAIT  = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [PIN_W-1:0]   pin_index;
  logic [COUNT_W-1:0] touch_count;
  logic               touch_seen;
  logic               poll_done;
  logic               out_valid;
  logic               out_stall;
  logic               touch_active;
  logic [PIN_W-1:0]   winning_pin;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [PIN_W-1:0]   cfg_highest_pin;

  int                 fail_count;
  int                 pending;
  int                 items_sent;
  int                 gap_pct;
  bit                 quiet;
  bit                 hold_off;

  touch_key_consensus_filter_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pin_index_i       (pin_index),
    .touch_count_i     (touch_count),
    .touch_seen_i      (touch_seen),
    .poll_done_i       (poll_done),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .touch_active_o    (touch_active),
    .winning_pin_o     (winning_pin),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_highest_pin_i (cfg_highest_pin)
  );

  tkcf_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .pin_index_i       (pin_index),
    .touch_count_i     (touch_count),
    .touch_seen_i      (touch_seen),
    .poll_done_i       (poll_done),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .touch_active_i    (touch_active),
    .winning_pin_i     (winning_pin),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_highest_pin_i (cfg_highest_pin),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_event(input logic [PIN_W-1:0] pin, input logic [COUNT_W-1:0] cnt,
                            input logic seen, input logic done);
    @(negedge clk_i);
    in_valid    <= 1'b1;
    pin_index   <= pin;
    touch_count <= cnt;
    touch_seen  <= seen;
    poll_done   <= done;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(99, 0) < gap_pct) idle_input($urandom_range(19, 1));
  endtask

  task automatic wait_for_results();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_highest_pin(input logic [PIN_W-1:0] value);
    idle_input(1);
    wait_for_results();
    @(negedge clk_i);
    cfg_valid       <= 1'b1;
    cfg_highest_pin <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // A few count updates, then a poll done that is armed most of the time.
  task automatic send_poll_round(input logic [PIN_W-1:0] favored);
    int               n;
    logic [PIN_W-1:0] pin;
    logic [COUNT_W-1:0] cnt;
    n = $urandom_range(4, 1);
    repeat (n) begin
      pin = ($urandom_range(3, 0) == 0) ? favored : PIN_W'($urandom_range(15, 0));
      cnt = (pin == favored) ? COUNT_W'($urandom_range(4095, 3000))
                             : COUNT_W'($urandom_range(2999, 0));
      maybe_gap();
      send_event(pin, cnt, $urandom_range(3, 0) == 0, 1'b0);
    end
    maybe_gap();
    send_event(favored, COUNT_W'($urandom_range(4095, 3000)),
               $urandom_range(9, 0) != 0, 1'b1);
  endtask

  // Output side backpressure: random bursts, one long hold on request.
  initial begin : result_backpressure
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(9, 0) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(19, 1);
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_touch_key_consensus_filter_unit failed");
    $finish;
  end

  initial begin : stimulus
    logic [PIN_W-1:0] phase_hp [PHASES];
    logic [PIN_W-1:0] favored;
    int               phase_end;
    int               ph;

    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    pin_index       = '0;
    touch_count     = '0;
    touch_seen      = 1'b0;
    poll_done       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_highest_pin = '0;
    items_sent      = 0;
    gap_pct         = 0;
    quiet           = 1'b0;
    hold_off        = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default scan range of nine pins, 0 to 8
    send_event(4'd0, 12'd0, 1'b0, 1'b1);        // poll done without touch: refill
    send_event(4'd3, 12'd4095, 1'b0, 1'b0);
    send_event(4'd15, 12'd4095, 1'b0, 1'b0);    // above scan range
    send_event(4'd5, 12'd100, 1'b1, 1'b1);      // touch and poll done together
    send_event(4'd2, 12'd4095, 1'b0, 1'b0);     // tie with pin 3
    send_event(4'd0, 12'd0, 1'b1, 1'b0);        // arm only
    send_event(4'd0, 12'd0, 1'b0, 1'b1);
    repeat (9) send_event(4'd1, 12'd1, 1'b1, 1'b1);  // fill ring with one winner

    write_highest_pin(4'd0);
    send_event(4'd0, 12'd0, 1'b0, 1'b1);
    send_event(4'd0, 12'd7, 1'b1, 1'b1);

    write_highest_pin(4'd15);
    send_event(4'd2, 12'd0, 1'b0, 1'b0);
    send_event(4'd3, 12'd0, 1'b0, 1'b0);
    send_event(4'd15, 12'd4095, 1'b1, 1'b1);
    send_event(4'd0, 12'd0, 1'b0, 1'b1);        // refill clipped to ring depth

    phase_hp    = '{4'd15, 4'd0, 4'd1, 4'd5, 4'd10, 4'd9};
    phase_hp[3] = PIN_W'($urandom_range(14, 2));
    for (ph = 0; ph < PHASES; ph++) begin
      write_highest_pin(phase_hp[ph]);
      quiet     = (ph == PHASES - 1);
      gap_pct   = 5 * $urandom_range(3, 0);
      favored   = PIN_W'($urandom_range(int'(phase_hp[ph]), 0));
      phase_end = items_sent + PHASE_ITEMS;
      if (ph == 1) hold_off = 1'b1;  // sender keeps offering while results back up
      while (items_sent < phase_end) begin
        if ($urandom_range(15, 0) == 0)
          favored = PIN_W'($urandom_range(int'(phase_hp[ph]), 0));
        if ($urandom_range(3, 0) == 0) begin
          maybe_gap();
          send_event(PIN_W'($urandom_range(15, 0)), COUNT_W'($urandom_range(4095, 0)),
                     1'($urandom_range(1, 0)), $urandom_range(3, 0) == 0);
        end else begin
          send_poll_round(favored);
        end
      end
    end

    idle_input(1);
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_touch_key_consensus_filter_unit passed");
    else
      $display("tb_touch_key_consensus_filter_unit failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tkcf_pkg.sv
rtl/tkcf_front.sv
rtl/tkcf_queue.sv
rtl/tkcf_back.sv
rtl/touch_key_consensus_filter_unit.sv
tb/tkcf_checker.sv
tb/tb_touch_key_consensus_filter_unit.sv
